### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define CSVF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// a stalled beat keeps valid and payload
`define CSVF_ASSERT_HOLD(label, vld, rdy, data) \
  `CSVF_ASSERT(label, vld && !rdy |=> vld && $stable(data))

`endif

### sv/csvf_pkg.sv
// ----------------------------------------------------------------------------
// csvf_pkg
// Types, widths, coefficient tables and saturation helpers for the cascaded
// state-variable filter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvf_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GLIDE_BITS     = 24;
  localparam int CODE_BITS      = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (GLIDE_BITS > CODE_BITS) ? GLIDE_BITS : CODE_BITS;

  localparam int ST_BITS   = 40;
  localparam int ST_FRAC   = 8;
  localparam int COEF_FRAC = 24;
  localparam int CUT_BITS  = COEF_FRAC + 1;
  localparam int STEP_BITS = CUT_BITS + 1;
  localparam int SUM_BITS  = ST_BITS + 4;

  localparam int MUL_SPLIT = ST_BITS / 2;
  localparam int PL_BITS   = MUL_SPLIT + CUT_BITS;
  localparam int PH_BITS   = ST_BITS - MUL_SPLIT + CUT_BITS + 1;
  localparam int FULL_BITS = ST_BITS + CUT_BITS + 1;
  localparam int PROD_BITS = FULL_BITS - COEF_FRAC;
  localparam int YSH_BITS  = ST_BITS - ST_FRAC;

  localparam int DIV_CNT_BITS = $clog2(STEP_BITS);

  localparam int CUT_MAX_CODE  = 240;
  localparam int DAMP_MAX_CODE = 128;
  localparam longint CUT_BASE   = 1440;
  localparam longint CUT_SLOPE  = 94;
  localparam longint CUT_DEN    = 24000;
  localparam longint DAMP_NUM   = 995;
  localparam longint DAMP_SCALE = 131072;
  localparam longint DAMP_DEN   = 1000;
  localparam longint COEF_ONE   = longint'(1) <<< COEF_FRAC;

  localparam logic [CUT_BITS-1:0]  CUTOFF_RESET   = CUT_BITS'(COEF_ONE);
  localparam logic [CODE_BITS-1:0] BAND_RES_RESET = CODE_BITS'(64);
  localparam logic [CODE_BITS-1:0] LOW_RES_RESET  = CODE_BITS'(8);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FILTER_MODE = 3'd0,
    REG_CUTOFF_CODE = 3'd1,
    REG_BAND_RES    = 3'd2,
    REG_LOW_RES     = 3'd3,
    REG_GLIDE       = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_FILTER,
    TS_DIVIDE
  } top_state_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_FF,
    CS_P1,
    CS_L1,
    CS_P2,
    CS_H1,
    CS_P3,
    CS_B1,
    CS_P4,
    CS_L2,
    CS_P5,
    CS_H2,
    CS_P6,
    CS_B2,
    CS_OUT,
    CS_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    MPH_LO,
    MPH_HI,
    MPH_SUM
  } mul_phase_t;

  typedef struct packed {
    logic                mode;
    logic [CUT_BITS-1:0] f;
    logic [CUT_BITS-1:0] bq;
    logic [CUT_BITS-1:0] lq;
  } coef_t;

  typedef struct packed {
    logic start;
    logic ack;
  } core_ctrl_t;

  typedef logic [CUT_BITS-1:0] cut_tab_t [0:CUT_MAX_CODE];
  typedef logic [CUT_BITS-1:0] damp_tab_t [0:DAMP_MAX_CODE];

  function automatic cut_tab_t build_cut_tab();
    cut_tab_t tab;
    longint   v;
    for (int c = 0; c <= CUT_MAX_CODE; c++) begin
      v = ((CUT_BASE + CUT_SLOPE * longint'(c)) * COEF_ONE + CUT_DEN / 2) / CUT_DEN;
      tab[c] = v[CUT_BITS-1:0];
    end
    return tab;
  endfunction

  function automatic damp_tab_t build_damp_tab();
    damp_tab_t tab;
    longint    v;
    for (int c = 0; c <= DAMP_MAX_CODE; c++) begin
      v = COEF_ONE - (longint'(c) * DAMP_NUM * DAMP_SCALE + DAMP_DEN / 2) / DAMP_DEN;
      tab[c] = v[CUT_BITS-1:0];
    end
    return tab;
  endfunction

  localparam cut_tab_t  CUT_TAB  = build_cut_tab();
  localparam damp_tab_t DAMP_TAB = build_damp_tab();

  function automatic logic [CUT_BITS-1:0] cutoff_of(input logic [CODE_BITS-1:0] code);
    logic [CUT_BITS-1:0] r;
    if (code > CODE_BITS'(CUT_MAX_CODE)) r = CUT_TAB[CUT_MAX_CODE];
    else r = CUT_TAB[code];
    return r;
  endfunction

  function automatic logic [CUT_BITS-1:0] damping_of(input logic [CODE_BITS-1:0] code);
    logic [CUT_BITS-1:0] r;
    if (code > CODE_BITS'(DAMP_MAX_CODE)) r = DAMP_TAB[DAMP_MAX_CODE];
    else r = DAMP_TAB[code];
    return r;
  endfunction

  function automatic logic signed [ST_BITS-1:0] sat_state(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [ST_BITS-1:0] r;
    if (v[SUM_BITS-1:ST_BITS-1] == '0 || v[SUM_BITS-1:ST_BITS-1] == '1) begin
      r = v[ST_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      r = {1'b1, {(ST_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(ST_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [YSH_BITS-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v[YSH_BITS-1:SAMPLE_BITS-1] == '0 || v[YSH_BITS-1:SAMPLE_BITS-1] == '1) begin
      r = v[SAMPLE_BITS-1:0];
    end else if (v[YSH_BITS-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/csvf_core.sv
// ----------------------------------------------------------------------------
// csvf_core
// Two-stage state-variable filter datapath: one split multiplier and one
// three-input saturating adder, stepped by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module csvf_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  csvf_pkg::core_ctrl_t                    ctrl,
  input  csvf_pkg::coef_t                         coef,
  input  logic signed [csvf_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                    done,
  output logic signed [csvf_pkg::SAMPLE_BITS-1:0] y
);
  import csvf_pkg::*;

  core_state_t state, state_next;
  mul_phase_t  mph, mph_next;

  logic signed [ST_BITS-1:0] low_one, band_one, low_two, band_two;
  logic signed [ST_BITS-1:0] x, h1, h2;
  logic [CUT_BITS-1:0]       ff, bq, lq;
  logic                      mode;

  logic [PL_BITS-1:0]          pl;
  logic signed [PH_BITS-1:0]   ph;
  logic signed [PROD_BITS-1:0] pq;
  logic signed [FULL_BITS-1:0] prod_full;
  logic signed [PROD_BITS-1:0] prod_q;
  logic signed [MUL_SPLIT:0]   mul_half;
  logic signed [PH_BITS-1:0]   mul_p;

  logic signed [ST_BITS-1:0]  mul_a;
  logic [CUT_BITS-1:0]        mul_c;
  logic                       mul_run;
  logic signed [SUM_BITS-1:0] add_a, add_b, add_c, add_sum;
  logic signed [ST_BITS-1:0]  add_sat;
  logic wr_ff, wr_l1, wr_h1, wr_b1, wr_l2, wr_h2, wr_b2, wr_y;

  logic signed [ST_BITS-1:0]  y_sel;
  logic signed [YSH_BITS-1:0] y_shift;

  // shared multiplier: low half unsigned, high half signed
  assign mul_half  = (mph == MPH_HI) ?
                     $signed({mul_a[ST_BITS-1], mul_a[ST_BITS-1:MUL_SPLIT]}) :
                     $signed({1'b0, mul_a[MUL_SPLIT-1:0]});
  assign mul_p     = PH_BITS'(mul_half) * PH_BITS'($signed({1'b0, mul_c}));
  assign prod_full = (FULL_BITS'(ph) <<< MUL_SPLIT) + FULL_BITS'(pl);
  assign prod_q    = prod_full[FULL_BITS-1:COEF_FRAC];

  // shared adder
  assign add_sum = add_a + add_b + add_c;
  assign add_sat = sat_state(add_sum);

  assign y_sel   = mode ? h2 : low_two;
  assign y_shift = y_sel[ST_BITS-1:ST_FRAC];

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: if (ctrl.start) state_next = CS_FF;
      CS_FF:   if (mph == MPH_SUM) state_next = CS_P1;
      CS_P1:   if (mph == MPH_SUM) state_next = CS_L1;
      CS_L1:   state_next = CS_P2;
      CS_P2:   if (mph == MPH_SUM) state_next = CS_H1;
      CS_H1:   state_next = CS_P3;
      CS_P3:   if (mph == MPH_SUM) state_next = CS_B1;
      CS_B1:   state_next = CS_P4;
      CS_P4:   if (mph == MPH_SUM) state_next = CS_L2;
      CS_L2:   state_next = mode ? CS_H2 : CS_P5;
      CS_P5:   if (mph == MPH_SUM) state_next = CS_H2;
      CS_H2:   state_next = CS_P6;
      CS_P6:   if (mph == MPH_SUM) state_next = CS_B2;
      CS_B2:   state_next = CS_OUT;
      CS_OUT:  state_next = CS_DONE;
      CS_DONE: if (ctrl.ack) state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    mph_next = MPH_LO;
    if (mul_run) begin
      case (mph)
        MPH_LO:  mph_next = MPH_HI;
        MPH_HI:  mph_next = MPH_SUM;
        default: mph_next = MPH_LO;
      endcase
    end
  end

  always_comb begin
    mul_a   = '0;
    mul_c   = '0;
    mul_run = 1'b0;
    add_a   = '0;
    add_b   = '0;
    add_c   = '0;
    wr_ff   = 1'b0;
    wr_l1   = 1'b0;
    wr_h1   = 1'b0;
    wr_b1   = 1'b0;
    wr_l2   = 1'b0;
    wr_h2   = 1'b0;
    wr_b2   = 1'b0;
    wr_y    = 1'b0;
    done    = 1'b0;
    case (state)
      CS_FF: begin
        mul_run = 1'b1;
        mul_a   = ST_BITS'(ff);
        mul_c   = ff;
        wr_ff   = (mph == MPH_SUM);
      end
      CS_P1: begin
        mul_run = 1'b1;
        mul_a   = band_one;
        mul_c   = ff;
      end
      CS_L1: begin
        add_a = SUM_BITS'(low_one);
        add_b = SUM_BITS'(pq);
        wr_l1 = 1'b1;
      end
      CS_P2: begin
        mul_run = 1'b1;
        mul_a   = band_one;
        mul_c   = bq;
      end
      CS_H1: begin
        add_a = SUM_BITS'(x);
        add_b = -SUM_BITS'(low_one);
        add_c = -SUM_BITS'(pq);
        wr_h1 = 1'b1;
      end
      CS_P3: begin
        mul_run = 1'b1;
        mul_a   = h1;
        mul_c   = ff;
      end
      CS_B1: begin
        add_a = SUM_BITS'(band_one);
        add_b = SUM_BITS'(pq);
        wr_b1 = 1'b1;
      end
      CS_P4: begin
        mul_run = 1'b1;
        mul_a   = band_two;
        mul_c   = ff;
      end
      CS_L2: begin
        add_a = SUM_BITS'(low_two);
        add_b = SUM_BITS'(pq);
        wr_l2 = 1'b1;
      end
      CS_P5: begin
        mul_run = 1'b1;
        mul_a   = low_two;
        mul_c   = lq;
      end
      CS_H2: begin
        if (mode) begin
          add_a = SUM_BITS'(h1);
          add_b = -SUM_BITS'(low_two);
        end else begin
          add_a = SUM_BITS'(low_one);
          add_b = -SUM_BITS'(pq);
        end
        add_c = -SUM_BITS'(band_two);
        wr_h2 = 1'b1;
      end
      CS_P6: begin
        mul_run = 1'b1;
        mul_a   = h2;
        mul_c   = ff;
      end
      CS_B2: begin
        add_a = SUM_BITS'(band_two);
        add_b = SUM_BITS'(pq);
        wr_b2 = 1'b1;
      end
      CS_OUT:  wr_y = 1'b1;
      CS_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CS_IDLE;
      mph      <= MPH_LO;
      low_one  <= '0;
      band_one <= '0;
      low_two  <= '0;
      band_two <= '0;
    end else begin
      state <= state_next;
      mph   <= mph_next;
      if (wr_l1) low_one <= add_sat;
      if (wr_b1) band_one <= add_sat;
      if (wr_l2) low_two <= add_sat;
      if (wr_b2) band_two <= add_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x    <= ST_BITS'(sample) <<< ST_FRAC;
      ff   <= coef.f;
      bq   <= coef.bq;
      lq   <= coef.lq;
      mode <= coef.mode;
    end
    if (wr_ff) ff <= prod_q[CUT_BITS-1:0];
    if (mul_run && mph == MPH_LO) pl <= mul_p[PL_BITS-1:0];
    if (mul_run && mph == MPH_HI) ph <= mul_p;
    if (mul_run && mph == MPH_SUM) pq <= prod_q;
    if (wr_h1) h1 <= add_sat;
    if (wr_h2) h2 <= add_sat;
    if (wr_y) y <= sat_sample(y_shift);
  end

endmodule

`default_nettype wire

### sv/cascaded_svf_filter_with_glide_unit.sv
// ----------------------------------------------------------------------------
// cascaded_svf_filter_with_glide_unit
// Two cascaded state-variable filter stages with a shared cutoff, selectable
// lowpass or highpass output, and a linear cutoff glide.
// ----------------------------------------------------------------------------
// A sample beat is taken only when the block is idle. Its result passes through
// the core's y register into the output register, and the block takes no new
// sample until the current one is finished; the pace is set by the shared 20x25
// multiplier, which works each product in low, high and sum phases, seven
// products in lowpass and six in highpass, plus one adder step per state update.
// A waiting result does not block the next sample; a finished sample waits only
// if the output register is still full. Writing cutoff_code while glide_samples
// is nonzero runs a restoring division for the ramp step, during which no sample
// or configuration beat is taken.
`default_nettype none

module cascaded_svf_filter_with_glide_unit (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [csvf_pkg::SAMPLE_BITS-1:0]    sample_in,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [csvf_pkg::SAMPLE_BITS-1:0]    sample_out,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [csvf_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [csvf_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
  import csvf_pkg::*;

  top_state_t state, state_next;
  core_ctrl_t ctrl;
  coef_t      coef;
  logic       core_done;
  logic signed [SAMPLE_BITS-1:0] core_y;

  logic                   filter_mode;
  logic [CODE_BITS-1:0]   band_res_code;
  logic [CODE_BITS-1:0]   low_res_code;
  logic [GLIDE_BITS-1:0]  glide_samples;
  logic [CUT_BITS-1:0]    cutoff_now;
  logic signed [STEP_BITS-1:0] glide_step;
  logic [GLIDE_BITS-1:0]  glide_left;

  logic [GLIDE_BITS-1:0]   div_rem;
  logic [STEP_BITS-1:0]    div_quo;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                    div_neg;
  logic [GLIDE_BITS:0]     div_shift;
  logic [GLIDE_BITS+1:0]   div_trial;
  logic                    div_ok;
  logic [STEP_BITS-1:0]    div_q_final;
  logic                    div_start;
  logic                    div_last;

  logic                        cfg_acc;
  logic                        cut_wr;
  logic [CUT_BITS-1:0]         cut_target;
  logic signed [STEP_BITS-1:0] cut_diff;
  logic [STEP_BITS-1:0]        cut_mag;
  logic signed [CUT_BITS+1:0]  glide_sum;
  logic [CUT_BITS-1:0]         glide_next;

  assign cfg_acc    = cfg_valid && cfg_ready;
  assign cut_wr     = cfg_acc && (cfg_index == REG_CUTOFF_CODE);
  assign cut_target = cutoff_of(cfg_data[CODE_BITS-1:0]);
  assign cut_diff   = STEP_BITS'(cut_target) - STEP_BITS'(cutoff_now);
  assign cut_mag    = cut_diff[STEP_BITS-1] ? -cut_diff : cut_diff;
  assign div_start  = cut_wr && (glide_samples != '0);

  assign div_shift   = {div_rem, div_quo[STEP_BITS-1]};
  assign div_trial   = {1'b0, div_shift} - {2'b00, glide_samples};
  assign div_ok      = !div_trial[GLIDE_BITS+1];
  assign div_q_final = {div_quo[STEP_BITS-2:0], div_ok};
  assign div_last    = (state == TS_DIVIDE) && (div_cnt == '0);

  assign glide_sum = {2'b00, cutoff_now} + (CUT_BITS+2)'(glide_step);
  always_comb begin
    if (glide_sum[CUT_BITS+1]) glide_next = '0;
    else if (glide_sum[CUT_BITS]) glide_next = '1;
    else glide_next = glide_sum[CUT_BITS-1:0];
  end

  assign coef.mode = filter_mode;
  assign coef.f    = cutoff_now;
  assign coef.bq   = damping_of(band_res_code);
  assign coef.lq   = damping_of(low_res_code);

  always_comb begin
    state_next = state;
    case (state)
      TS_IDLE: begin
        if (ctrl.start) state_next = TS_FILTER;
        else if (div_start) state_next = TS_DIVIDE;
      end
      TS_FILTER: if (ctrl.ack) state_next = TS_IDLE;
      TS_DIVIDE: if (div_cnt == '0) state_next = TS_IDLE;
      default:   state_next = TS_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == TS_IDLE) && !cfg_valid;
    cfg_ready  = (state == TS_IDLE);
    ctrl.start = in_valid && in_ready;
    ctrl.ack   = core_done && (!out_valid || out_ready);
  end

  csvf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .coef   (coef),
    .sample (sample_in),
    .done   (core_done),
    .y      (core_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= TS_IDLE;
      out_valid     <= 1'b0;
      filter_mode   <= 1'b0;
      band_res_code <= BAND_RES_RESET;
      low_res_code  <= LOW_RES_RESET;
      glide_samples <= '0;
      cutoff_now    <= CUTOFF_RESET;
      glide_step    <= '0;
      glide_left    <= '0;
    end else begin
      state <= state_next;
      if (ctrl.ack) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_acc) begin
        case (cfg_index)
          REG_FILTER_MODE: filter_mode <= cfg_data[0];
          REG_CUTOFF_CODE: begin
            if (glide_samples == '0) cutoff_now <= cut_target;
            else glide_left <= glide_samples;
          end
          REG_BAND_RES: band_res_code <= cfg_data[CODE_BITS-1:0];
          REG_LOW_RES:  low_res_code <= cfg_data[CODE_BITS-1:0];
          REG_GLIDE: begin
            glide_samples <= cfg_data[GLIDE_BITS-1:0];
            if (cfg_data[GLIDE_BITS-1:0] == '0) glide_step <= '0;
          end
          default: ;
        endcase
      end
      if (div_last) glide_step <= div_neg ? -$signed(div_q_final) : $signed(div_q_final);
      // ramp advances once per finished sample
      if (ctrl.ack && glide_step != '0) begin
        if (glide_left != '0) begin
          cutoff_now <= glide_next;
          glide_left <= glide_left - 1'b1;
        end else begin
          glide_step <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ack) sample_out <= core_y;
    if (div_start) begin
      div_rem <= '0;
      div_quo <= cut_mag;
      div_neg <= cut_diff[STEP_BITS-1];
      div_cnt <= DIV_CNT_BITS'(STEP_BITS - 1);
    end else if (state == TS_DIVIDE) begin
      div_rem <= div_ok ? div_trial[GLIDE_BITS-1:0] : div_shift[GLIDE_BITS-1:0];
      div_quo <= div_q_final;
      div_cnt <= div_cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

### sv/csvf_checker.sv
// ----------------------------------------------------------------------------
// csvf_port_checker
// Port-level checks on the cascaded filter: busy after a sample beat, no
// premature result, in_ready only with cfg_ready, and a held output beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module csvf_port_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [csvf_pkg::SAMPLE_BITS-1:0] sample_out,
  input logic                                    cfg_ready
);

  `CSVF_ASSERT(a_busy_after_sample, in_valid && in_ready |=> !in_ready && !cfg_ready)
  `CSVF_ASSERT(a_no_early_result, in_valid && in_ready && !out_valid |=> !out_valid)
  `CSVF_ASSERT(a_in_ready_cfg_ready, in_ready |-> cfg_ready)
  `CSVF_ASSERT_HOLD(a_out_hold, out_valid, out_ready, sample_out)

endmodule

bind cascaded_svf_filter_with_glide_unit csvf_port_checker u_checker (.*);

`default_nettype wire

### tb/csvf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csvf_checker
// Watches the sample, result and register channels of the cascaded
// state-variable filter, predicts every filtered sample from its own copy of
// the filter state and registers, and compares results in order.
// ----------------------------------------------------------------------------
module csvf_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic signed [csvf_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [csvf_pkg::SAMPLE_BITS-1:0] sample_out,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [csvf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [csvf_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output int                                      fail_count,
  output int                                      pending
);
  import csvf_pkg::*;

  localparam longint Q24_ONE   = longint'(1) <<< 24;
  localparam longint ST_TOP    = (longint'(1) <<< (ST_BITS - 1)) - 1;
  localparam longint ST_BOT    = -(longint'(1) <<< (ST_BITS - 1));
  localparam longint OUT_TOP   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_BOT   = -(longint'(1) <<< (SAMPLE_BITS - 1));
  localparam longint CUT_LIMIT = (longint'(1) <<< CUT_BITS) - 1;

  logic                    mode_q;
  logic [CODE_BITS-1:0]    cut_code_q;
  logic [CODE_BITS-1:0]    band_res_q;
  logic [CODE_BITS-1:0]    low_res_q;
  logic [GLIDE_BITS-1:0]   glide_len_q;

  logic signed [ST_BITS-1:0]   low1, band1, low2, band2;
  logic [CUT_BITS-1:0]         cut_now;
  logic signed [STEP_BITS-1:0] glide_inc;
  logic [GLIDE_BITS-1:0]       glide_cnt;

  logic signed [SAMPLE_BITS-1:0] expected_samples [$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic longint sat_st(input longint v);
    if (v > ST_TOP) return ST_TOP;
    if (v < ST_BOT) return ST_BOT;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input longint v);
    if (v > OUT_TOP) return SAMPLE_BITS'(OUT_TOP);
    if (v < OUT_BOT) return SAMPLE_BITS'(OUT_BOT);
    return SAMPLE_BITS'(v);
  endfunction

  function automatic longint scale_q24(input longint a, input longint c);
    return (a * c) >>> 24;
  endfunction

  function automatic longint cut_coef(input logic [CODE_BITS-1:0] code);
    longint c;
    c = (code > CODE_BITS'(240)) ? 240 : longint'(code);
    return ((1440 + 94 * c) * Q24_ONE + 12000) / 24000;
  endfunction

  function automatic longint damp_coef(input logic [CODE_BITS-1:0] code);
    longint c;
    c = (code > CODE_BITS'(128)) ? 128 : longint'(code);
    return Q24_ONE - (c * 995 * 131072 + 500) / 1000;
  endfunction

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    longint target, diff, mag, q;
    case (idx)
      REG_FILTER_MODE: mode_q = data[0];
      REG_CUTOFF_CODE: begin
        cut_code_q = data[CODE_BITS-1:0];
        target = cut_coef(cut_code_q);
        if (glide_len_q == '0) begin
          cut_now = CUT_BITS'(target);
        end else begin
          diff = target - longint'(cut_now);
          mag = (diff < 0) ? -diff : diff;
          q = mag / longint'(glide_len_q);
          glide_cnt = glide_len_q;
          glide_inc = STEP_BITS'((diff < 0) ? -q : q);
        end
      end
      REG_BAND_RES: band_res_q = data[CODE_BITS-1:0];
      REG_LOW_RES: low_res_q = data[CODE_BITS-1:0];
      REG_GLIDE: begin
        glide_len_q = data[GLIDE_BITS-1:0];
        if (glide_len_q == '0) glide_inc = '0;
      end
      default: ;
    endcase
  endtask

  task automatic filter_sample(input logic signed [SAMPLE_BITS-1:0] x_in,
                               output logic signed [SAMPLE_BITS-1:0] y_out);
    longint x, f, ff, bq, lq, l1, b1, l2, b2, h1, h2, y, nc;
    x  = longint'(x_in) * 256;
    f  = longint'(cut_now);
    ff = (f * f) >>> 24;
    bq = damp_coef(band_res_q);
    lq = damp_coef(low_res_q);
    l1 = longint'(low1);
    b1 = longint'(band1);
    l2 = longint'(low2);
    b2 = longint'(band2);
    if (glide_inc != 0 && glide_cnt == 0) glide_inc = '0;

    l1 = sat_st(l1 + scale_q24(b1, ff));
    h1 = sat_st(x - l1 - scale_q24(b1, bq));
    b1 = sat_st(b1 + scale_q24(h1, ff));
    l2 = sat_st(l2 + scale_q24(b2, ff));
    if (mode_q) h2 = sat_st(h1 - l2 - b2);
    else h2 = sat_st(l1 - scale_q24(l2, lq) - b2);
    b2 = sat_st(b2 + scale_q24(h2, ff));

    low1  = ST_BITS'(l1);
    band1 = ST_BITS'(b1);
    low2  = ST_BITS'(l2);
    band2 = ST_BITS'(b2);

    y = mode_q ? h2 : l2;
    y_out = sat_out(y >>> ST_FRAC);

    if (glide_inc != 0 && glide_cnt != 0) begin
      nc = f + longint'(glide_inc);
      if (nc < 0) nc = 0;
      if (nc > CUT_LIMIT) nc = CUT_LIMIT;
      cut_now = CUT_BITS'(nc);
      glide_cnt = glide_cnt - 1'b1;
    end
  endtask

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst) begin
      mode_q      = 1'b0;
      cut_code_q  = CODE_BITS'(240);
      band_res_q  = BAND_RES_RESET;
      low_res_q   = LOW_RES_RESET;
      glide_len_q = '0;
      low1 = '0;
      band1 = '0;
      low2 = '0;
      band2 = '0;
      cut_now   = CUTOFF_RESET;
      glide_inc = '0;
      glide_cnt = '0;
      expected_samples.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, actual %0d",
                   $time, sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (sample_out !== want) begin
            fail_count++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, sample_out);
          end
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        filter_sample(sample_in, want);
        expected_samples.push_back(want);
      end
    end
    pending = expected_samples.size();
  end

endmodule

### tb/cascaded_svf_filter_with_glide_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cascaded_svf_filter_with_glide_unit_tb
// Drives audio samples and register writes into the cascaded state-variable
// filter with bursty input and a stalling output; the checker beside the
// block predicts and compares every filtered sample.
// ----------------------------------------------------------------------------
module cascaded_svf_filter_with_glide_unit_tb;
  import csvf_pkg::*;

  localparam int ITEMS         = 1250;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 600;
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int UNUSED_FIRST  = 5;
  localparam int UNUSED_LAST   = (1 << CFG_INDEX_BITS) - 1;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;

  int fail_count;
  int pending;
  int sent;
  int burst_left;
  int quiet;
  bit hold_go;
  bit hold_done;
  bit sq_high;
  int sq_left;
  int sq_amp;

  cascaded_svf_filter_with_glide_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  csvf_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // output side: stall patterns, plus one long hold-off to back up the input
  initial begin : receiver
    int pat;
    int span;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_go && !hold_done && in_valid) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        pat = $urandom_range(0, 2);
        span = $urandom_range(10, 200);
        repeat (span) begin
          case (pat)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 7) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] v);
    int gap;
    in_valid  <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ((hold_go && !hold_done) || $urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic await_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 40) return SAMPLE_BITS'($urandom);
    if (r < 65) begin
      s = int'($urandom_range(0, 8191)) - 4096;
      return SAMPLE_BITS'(s);
    end
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return S_MAX;
        1: return S_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    if (sq_left == 0) begin
      sq_left = $urandom_range(2, 40);
      sq_amp = $urandom_range(1, 8388607);
      sq_high = ~sq_high;
    end
    sq_left--;
    return sq_high ? SAMPLE_BITS'(sq_amp) : SAMPLE_BITS'(-sq_amp);
  endfunction

  function automatic logic [CODE_BITS-1:0] pick_cut_code();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CODE_BITS'(240);
      2: return CODE_BITS'($urandom_range(241, 255));
      default: return CODE_BITS'($urandom_range(0, 240));
    endcase
  endfunction

  function automatic logic [CODE_BITS-1:0] pick_res_code();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CODE_BITS'(128);
      2: return CODE_BITS'($urandom_range(129, 255));
      default: return CODE_BITS'($urandom_range(0, 128));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_glide();
    case ($urandom_range(0, 7))
      0, 1: return '0;
      2: return CFG_DATA_BITS'(1);
      3: return '1;
      4: return CFG_DATA_BITS'($urandom);
      default: return CFG_DATA_BITS'($urandom_range(2, 64));
    endcase
  endfunction

  task automatic shuffle_registers();
    logic [CFG_DATA_BITS-CODE_BITS-1:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? '0 : (CFG_DATA_BITS-CODE_BITS)'($urandom);
    if ($urandom_range(0, 1) == 1) write_reg(REG_FILTER_MODE, CFG_DATA_BITS'($urandom));
    if ($urandom_range(0, 1) == 1) write_reg(REG_BAND_RES, {junk, pick_res_code()});
    if ($urandom_range(0, 1) == 1) write_reg(REG_LOW_RES, {junk, pick_res_code()});
    if ($urandom_range(0, 9) < 6) write_reg(REG_GLIDE, pick_glide());
    if ($urandom_range(0, 9) < 7) write_reg(REG_CUTOFF_CODE, {junk, pick_cut_code()});
    if ($urandom_range(0, 9) < 2)
      write_reg(CFG_INDEX_BITS'($urandom_range(UNUSED_FIRST, UNUSED_LAST)),
                CFG_DATA_BITS'($urandom));
  endtask

  initial begin
    int n;
    rst        = 1'b1;
    in_valid   = 1'b0;
    sample_in  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    sent       = 0;
    burst_left = 0;
    quiet      = 0;
    hold_go    = 1'b0;
    hold_done  = 1'b0;
    sq_high    = 1'b0;
    sq_left    = 0;
    sq_amp     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, lowpass at full cutoff, driven into saturation
    offer_sample(S_MAX);
    offer_sample(S_MIN);
    offer_sample(S_MAX);
    offer_sample(S_MIN);
    offer_sample('0);
    offer_sample('1);
    offer_sample(SAMPLE_BITS'(1));
    offer_sample(24'sh555555);

    await_idle();
    write_reg(REG_FILTER_MODE, CFG_DATA_BITS'(1));
    offer_sample(S_MIN);
    offer_sample(S_MAX);
    offer_sample(S_MAX);
    offer_sample(24'shAAAAAA);
    offer_sample('0);

    // short glide down to the lowest cutoff, ramp runs out mid-stream
    await_idle();
    write_reg(REG_GLIDE, CFG_DATA_BITS'(3));
    write_reg(REG_CUTOFF_CODE, '0);
    write_reg(CFG_INDEX_BITS'(UNUSED_LAST), '1);
    repeat (6) offer_sample(next_sample());

    // codes above range act as the top code
    await_idle();
    write_reg(REG_GLIDE, '0);
    write_reg(REG_CUTOFF_CODE, CFG_DATA_BITS'(255));
    write_reg(REG_BAND_RES, CFG_DATA_BITS'(255));
    write_reg(REG_LOW_RES, CFG_DATA_BITS'(200));
    write_reg(REG_FILTER_MODE, '0);
    repeat (5) offer_sample(next_sample());

    hold_go = 1'b1;
    while (sent < ITEMS) begin
      await_idle();
      shuffle_registers();
      n = $urandom_range(30, 110);
      repeat (n) offer_sample(next_sample());
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
